[hw/rtl/assert_macros.svh]
// assertion macros, included by press_motion_profile_position
// expects clk_i and rst_ni in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define MPP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// checked during reset as well
`define MPP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");

`endif

[hw/rtl/mpp_pkg.sv]
// types, constants and codes for the press ram position profile
// no dependencies
`timescale 1ns / 1ps

package mpp_pkg;

  localparam int TIME_BITS   = 32;
  localparam int HEIGHT_BITS = 16;
  localparam int TICK_BITS   = 16;
  localparam int CFG_BITS    = 16;
  localparam int IDX_BITS    = 3;
  localparam int QUO_BITS    = TICK_BITS + 1;
  localparam int PROD_BITS   = 2 * TICK_BITS;
  localparam int DEN_BITS    = 3 * TICK_BITS;
  localparam int NUM_BITS    = 4 * TICK_BITS;
  localparam int POS_BITS    = QUO_BITS + 3;

  typedef enum logic [IDX_BITS-1:0] {
    REG_DROP_START = 3'd0,
    REG_DROP_END   = 3'd1,
    REG_RISE_START = 3'd2,
    REG_CYCLE_END  = 3'd3,
    REG_TOP        = 3'd4,
    REG_SWITCH     = 3'd5,
    REG_BOTTOM     = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_TOP      = 3'd0,
    PH_ACC_DOWN = 3'd1,
    PH_DEC_DOWN = 3'd2,
    PH_BOTTOM   = 3'd3,
    PH_ACC_UP   = 3'd4,
    PH_DEC_UP   = 3'd5
  } phase_e;

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic signed [HEIGHT_BITS-1:0] height_t;

  typedef struct packed {
    tick_t   t0;
    tick_t   t2;
    tick_t   t3;
    tick_t   t5;
    height_t h0;
    height_t h2;
    tick_t   a;
    tick_t   b;
    tick_t   d;
    logic    falling_up;
    logic    err;
  } cfg_t;

  typedef struct packed {
    phase_e phase;
    logic   zero;
  } side_t;

endpackage

[hw/rtl/mpp_if.sv]
// stream interfaces for the time, result and register write channels
// depends on mpp_pkg
`timescale 1ns / 1ps

interface mpp_in_if;
  logic                           valid;
  logic                           ready;
  logic [mpp_pkg::TIME_BITS-1:0]  time_now;
  modport source (output valid, output time_now, input ready);
  modport sink (input valid, input time_now, output ready);
endinterface

interface mpp_out_if;
  logic                             valid;
  logic                             ready;
  logic [mpp_pkg::HEIGHT_BITS-1:0]  position;
  logic [2:0]                       phase;
  logic                             config_error;
  modport source (output valid, output position, output phase, output config_error,
                  input ready);
  modport sink (input valid, input position, input phase, input config_error,
                output ready);
endinterface

interface mpp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mpp_pkg::IDX_BITS-1:0]  index;
  logic [mpp_pkg::CFG_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/mpp_cfg.sv]
// register file and derived stroke constants
// depends on mpp_pkg and mpp_if
`timescale 1ns / 1ps

module mpp_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  mpp_cfg_if.sink        cfg_i,
  output mpp_pkg::cfg_t  cfg_o
);

  mpp_pkg::tick_t   t0_q, t2_q, t3_q, t5_q;
  mpp_pkg::height_t h0_q, h1_q, h2_q;
  mpp_pkg::cfg_t    cfg_d, cfg_q;

  logic signed [mpp_pkg::HEIGHT_BITS:0] h0x, h1x, h2x, lo, hi, h1c, da, db, dd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_q <= 16'd0;
      t2_q <= 16'd1000;
      t3_q <= 16'd2000;
      t5_q <= 16'd3000;
      h0_q <= 16'sd25600;
      h1_q <= 16'sd12800;
      h2_q <= 16'sd0;
    end else if (cfg_i.valid) begin
      unique case (mpp_pkg::cfg_idx_e'(cfg_i.index))
        mpp_pkg::REG_DROP_START: t0_q <= cfg_i.data;
        mpp_pkg::REG_DROP_END:   t2_q <= cfg_i.data;
        mpp_pkg::REG_RISE_START: t3_q <= cfg_i.data;
        mpp_pkg::REG_CYCLE_END:  t5_q <= cfg_i.data;
        mpp_pkg::REG_TOP:        h0_q <= cfg_i.data;
        mpp_pkg::REG_SWITCH:     h1_q <= cfg_i.data;
        mpp_pkg::REG_BOTTOM:     h2_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    h0x = (mpp_pkg::HEIGHT_BITS+1)'(h0_q);
    h1x = (mpp_pkg::HEIGHT_BITS+1)'(h1_q);
    h2x = (mpp_pkg::HEIGHT_BITS+1)'(h2_q);
    lo  = (h0x < h2x) ? h0x : h2x;
    hi  = (h0x < h2x) ? h2x : h0x;
    h1c = (h1x < lo) ? lo : ((h1x > hi) ? hi : h1x);
    da  = h0x - h1c;
    db  = h1c - h2x;
    dd  = h0x - h2x;
    cfg_d.t0 = t0_q;
    cfg_d.t2 = t2_q;
    cfg_d.t3 = t3_q;
    cfg_d.t5 = t5_q;
    cfg_d.h0 = h0_q;
    cfg_d.h2 = h2_q;
    cfg_d.a  = mpp_pkg::tick_t'(da[mpp_pkg::HEIGHT_BITS] ? -da : da);
    cfg_d.b  = mpp_pkg::tick_t'(db[mpp_pkg::HEIGHT_BITS] ? -db : db);
    cfg_d.d  = mpp_pkg::tick_t'(dd[mpp_pkg::HEIGHT_BITS] ? -dd : dd);
    cfg_d.falling_up = (h0x < h2x);
    cfg_d.err = (t0_q > t2_q) || (t2_q > t3_q) || (t3_q > t5_q) ||
                (t5_q == '0) || (h0_q == h2_q);
  end

  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/mpp_fold.sv]
// pipelined fold of the timestamp into one cycle, one dividend bit per stage
// depends on mpp_pkg
`timescale 1ns / 1ps

module mpp_fold (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [mpp_pkg::TIME_BITS-1:0]  time_i,
  input  mpp_pkg::tick_t                 t5_i,
  output logic                           valid_o,
  output mpp_pkg::tick_t                 tick_o
);

  localparam int N = mpp_pkg::TIME_BITS;

  logic                 valid_q [N];
  mpp_pkg::tick_t       rem_q   [N];
  logic [N-1:0]         bits_q  [N];
  logic                 nz_q    [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                            v_in;
    mpp_pkg::tick_t                  r_in;
    logic [N-1:0]                    b_in;
    logic                            nz_in;
    logic [mpp_pkg::TICK_BITS:0]     r_sh, r_new, div_x;

    if (k == 0) begin : g_first
      assign v_in  = valid_i;
      assign r_in  = '0;
      assign b_in  = time_i;
      assign nz_in = (time_i != '0);
    end else begin : g_next
      assign v_in  = valid_q[k-1];
      assign r_in  = rem_q[k-1];
      assign b_in  = bits_q[k-1];
      assign nz_in = nz_q[k-1];
    end

    assign div_x = {1'b0, t5_i};
    assign r_sh  = {r_in, b_in[N-1]};
    assign r_new = (r_sh >= div_x) ? r_sh - div_x : r_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= r_new[mpp_pkg::TICK_BITS-1:0];
        bits_q[k] <= {b_in[N-2:0], 1'b0};
        nz_q[k]   <= nz_in;
      end
    end
  end

  // a nonzero multiple of the cycle length lands on the cycle end
  assign valid_o = valid_q[N-1];
  assign tick_o  = (rem_q[N-1] == '0 && nz_q[N-1]) ? t5_i : rem_q[N-1];

endmodule

[hw/rtl/mpp_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on mpp_pkg
`timescale 1ns / 1ps

module mpp_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [mpp_pkg::NUM_BITS-1:0]      num_i,
  input  logic [mpp_pkg::DEN_BITS-1:0]      den_i,
  input  mpp_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic [mpp_pkg::QUO_BITS-1:0]      quo_o,
  output logic [mpp_pkg::DEN_BITS-1:0]      rem_o,
  output logic [mpp_pkg::DEN_BITS-1:0]      den_o,
  output mpp_pkg::side_t                    side_o
);

  localparam int N = mpp_pkg::QUO_BITS;

  logic                             valid_q [N];
  logic [mpp_pkg::NUM_BITS-1:0]     rem_q   [N];
  logic [mpp_pkg::DEN_BITS-1:0]     den_q   [N];
  logic [N-1:0]                     quo_q   [N];
  mpp_pkg::side_t                   side_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int SH = N - 1 - k;
    logic                           v_in;
    logic [mpp_pkg::NUM_BITS-1:0]   r_in, dsh;
    logic [mpp_pkg::DEN_BITS-1:0]   d_in;
    logic [N-1:0]                   q_in;
    mpp_pkg::side_t                 s_in;
    logic                           take;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = num_i;
      assign d_in = den_i;
      assign q_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = valid_q[k-1];
      assign r_in = rem_q[k-1];
      assign d_in = den_q[k-1];
      assign q_in = quo_q[k-1];
      assign s_in = side_q[k-1];
    end

    assign dsh  = mpp_pkg::NUM_BITS'(d_in) << SH;
    assign take = (r_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? r_in - dsh : r_in;
        den_q[k]  <= d_in;
        quo_q[k]  <= {q_in[N-2:0], take};
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign rem_o   = rem_q[N-1][mpp_pkg::DEN_BITS-1:0];
  assign den_o   = den_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

[hw/rtl/press_motion_profile_position.sv]
// Press ram position profile. Takes one timestamp beat per cycle and returns one
// result beat per timestamp, in order; the path runs through the 32-stage cycle
// fold, five stroke and multiply stages, the 17-stage quotient divider and the
// output register. A stall at the result side holds the whole pipeline. Register
// writes take effect after the register file and then the derived constant register.
// depends on mpp_pkg, mpp_if, mpp_cfg, mpp_fold, mpp_div and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module press_motion_profile_position (
  input  logic        clk_i,
  input  logic        rst_ni,
  mpp_in_if.sink      in_i,
  mpp_out_if.source   out_o,
  mpp_cfg_if.sink     cfg_i
);

  mpp_pkg::cfg_t cfg;
  logic          en;

  logic            fold_v;
  mpp_pkg::tick_t  fold_t;

  // stage 1: stroke selection
  logic             v1_q;
  mpp_pkg::phase_e  ph1_q, ph1_d;
  mpp_pkg::tick_t   span1_q, xs1_q, xe1_q, span1_d, xs1_d, xe1_d;

  // stage 2: switch point products
  logic                             v2_q;
  mpp_pkg::phase_e                  ph2_q;
  logic [mpp_pkg::PROD_BITS-1:0]    l2_q, r2_q, sq2_q;
  mpp_pkg::tick_t                   xs2_q, xe2_q;

  // stage 3: phase and operands
  logic                             v3_q;
  mpp_pkg::phase_e                  ph3_q, ph3_d;
  mpp_pkg::tick_t                   x3_q, part3_q, x3_d, part3_d;
  logic [mpp_pkg::PROD_BITS-1:0]    sq3_q;
  logic                             accel;

  // stage 4 and 5: numerator and denominator
  logic                             v4_q, v5_q;
  mpp_pkg::side_t                   s4_q, s5_q;
  logic [mpp_pkg::PROD_BITS-1:0]    xd4_q;
  logic [mpp_pkg::DEN_BITS-1:0]     den4_q, den5_q;
  logic [mpp_pkg::NUM_BITS-1:0]     num5_q;

  // divider result
  logic                             dv;
  logic [mpp_pkg::QUO_BITS-1:0]     quo;
  logic [mpp_pkg::DEN_BITS-1:0]     rem, den;
  mpp_pkg::side_t                   ds;

  // output
  logic                             out_v_q;
  mpp_pkg::height_t                 pos_q, pos_d;
  mpp_pkg::phase_e                  phase_q, phase_d;
  logic                             err_q;
  logic                             up, rnd;
  mpp_pkg::height_t                 ref_h;
  logic [mpp_pkg::DEN_BITS:0]       rem2, den2;
  logic signed [mpp_pkg::POS_BITS-1:0] ref_w, pos_w;
  logic [mpp_pkg::POS_BITS-1:0]     off_u;

  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  mpp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  mpp_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .time_i  (in_i.time_now),
    .t5_i    (cfg.t5),
    .valid_o (fold_v),
    .tick_o  (fold_t)
  );

  always_comb begin
    span1_d = '0;
    xs1_d   = '0;
    xe1_d   = '0;
    if (fold_t < cfg.t0) begin
      ph1_d = mpp_pkg::PH_TOP;
    end else if (fold_t < cfg.t2) begin
      ph1_d   = mpp_pkg::PH_ACC_DOWN;
      span1_d = cfg.t2 - cfg.t0;
      xs1_d   = fold_t - cfg.t0;
      xe1_d   = cfg.t2 - fold_t;
    end else if (fold_t < cfg.t3) begin
      ph1_d = mpp_pkg::PH_BOTTOM;
    end else begin
      ph1_d   = mpp_pkg::PH_ACC_UP;
      span1_d = cfg.t5 - cfg.t3;
      xs1_d   = fold_t - cfg.t3;
      xe1_d   = cfg.t5 - fold_t;
    end
  end

  always_comb begin
    accel   = (l2_q < r2_q);
    ph3_d   = ph2_q;
    x3_d    = '0;
    part3_d = '0;
    unique case (ph2_q)
      mpp_pkg::PH_ACC_DOWN: begin
        ph3_d   = accel ? mpp_pkg::PH_ACC_DOWN : mpp_pkg::PH_DEC_DOWN;
        x3_d    = accel ? xs2_q : xe2_q;
        part3_d = accel ? cfg.a : cfg.b;
      end
      mpp_pkg::PH_ACC_UP: begin
        ph3_d   = accel ? mpp_pkg::PH_ACC_UP : mpp_pkg::PH_DEC_UP;
        x3_d    = accel ? xs2_q : xe2_q;
        part3_d = accel ? cfg.b : cfg.a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= fold_v;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph1_q   <= ph1_d;
      span1_q <= span1_d;
      xs1_q   <= xs1_d;
      xe1_q   <= xe1_d;

      ph2_q   <= ph1_q;
      xs2_q   <= xs1_q;
      xe2_q   <= xe1_q;
      l2_q    <= mpp_pkg::PROD_BITS'(xs1_q) * mpp_pkg::PROD_BITS'(cfg.d);
      r2_q    <= mpp_pkg::PROD_BITS'((ph1_q == mpp_pkg::PH_ACC_DOWN) ? cfg.a : cfg.b) *
                 mpp_pkg::PROD_BITS'(span1_q);
      sq2_q   <= mpp_pkg::PROD_BITS'(span1_q) * mpp_pkg::PROD_BITS'(span1_q);

      ph3_q   <= ph3_d;
      x3_q    <= x3_d;
      part3_q <= part3_d;
      sq3_q   <= sq2_q;

      s4_q.phase <= ph3_q;
      s4_q.zero  <= (x3_q == '0) || (part3_q == '0);
      xd4_q      <= mpp_pkg::PROD_BITS'(x3_q) * mpp_pkg::PROD_BITS'(cfg.d);
      den4_q     <= mpp_pkg::DEN_BITS'(part3_q) * mpp_pkg::DEN_BITS'(sq3_q);

      s5_q   <= s4_q;
      den5_q <= den4_q;
      num5_q <= mpp_pkg::NUM_BITS'(xd4_q) * mpp_pkg::NUM_BITS'(xd4_q);
    end
  end

  mpp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .num_i   (num5_q),
    .den_i   (den5_q),
    .side_i  (s5_q),
    .valid_o (dv),
    .quo_o   (quo),
    .rem_o   (rem),
    .den_o   (den),
    .side_o  (ds)
  );

  // round to nearest, ties toward +infinity
  always_comb begin
    up    = (ds.phase == mpp_pkg::PH_ACC_DOWN || ds.phase == mpp_pkg::PH_DEC_UP) ?
            cfg.falling_up : !cfg.falling_up;
    ref_h = (ds.phase == mpp_pkg::PH_TOP || ds.phase == mpp_pkg::PH_ACC_DOWN ||
             ds.phase == mpp_pkg::PH_DEC_UP) ? cfg.h0 : cfg.h2;
    rem2  = {rem, 1'b0};
    den2  = {1'b0, den};
    rnd   = up ? (rem2 >= den2) : (rem2 > den2);
    off_u = ds.zero ? '0 : mpp_pkg::POS_BITS'(quo) + mpp_pkg::POS_BITS'(rnd);
    ref_w = mpp_pkg::POS_BITS'(ref_h);
    pos_w = up ? ref_w + $signed(off_u) : ref_w - $signed(off_u);
    if (cfg.err) begin
      pos_d   = cfg.h0;
      phase_d = mpp_pkg::PH_TOP;
    end else begin
      pos_d   = pos_w[mpp_pkg::HEIGHT_BITS-1:0];
      phase_d = ds.phase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      err_q   <= cfg.err;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.position     = pos_q;
  assign out_o.phase        = phase_q;
  assign out_o.config_error = err_q;

  `MPP_ASSERT(a_err_top, out_v_q && err_q |-> phase_q == mpp_pkg::PH_TOP && pos_q == cfg.h0)
  `MPP_ASSERT(a_hold_top, out_v_q && !err_q && phase_q == mpp_pkg::PH_TOP |-> pos_q == cfg.h0)
  `MPP_ASSERT(a_hold_bot, out_v_q && !err_q && phase_q == mpp_pkg::PH_BOTTOM |-> pos_q == cfg.h2)
  `MPP_ASSERT_ALWAYS(a_rst_idle, !rst_ni ##1 !rst_ni |-> !out_v_q && !v1_q && !v5_q)

endmodule
